[hdl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error(msg);

// Next-cycle implication that is also checked during reset.
`define ASSERT_NEXT_RAW(label, clk, a, b, msg) \
  label: assert property (@(posedge clk) (a) |=> (b)) \
    else $error(msg);

`endif

[hdl/dsss_pkg.sv]
`timescale 1ns / 1ps

package dsss_pkg;

  localparam int VALUE_W        = 27;
  localparam int DIGITS_DEFAULT = 8;
  localparam int SEL_W          = 8;
  localparam int SEG_W          = 8;
  localparam int POS_W          = 3;
  localparam int BCD_W          = 4;

  localparam logic [SEG_W-1:0] POINT_BIT = 8'h80;

  // Largest value the display can show, 10^digits - 1.
  function automatic logic [VALUE_W-1:0] display_limit(input int digits);
    longint lim;
    lim = 1;
    for (int k = 0; k < digits; k++) begin
      lim = lim * 10;
    end
    return VALUE_W'(lim - 1);
  endfunction

  // Common-cathode segment codes, segments a..g in bits 0..6.
  function automatic logic [SEG_W-1:0] seg_code(input logic [BCD_W-1:0] digit);
    logic [SEG_W-1:0] code;
    case (digit)
      4'd0:    code = 8'h3f;
      4'd1:    code = 8'h06;
      4'd2:    code = 8'h5b;
      4'd3:    code = 8'h4f;
      4'd4:    code = 8'h66;
      4'd5:    code = 8'h6d;
      4'd6:    code = 8'h7d;
      4'd7:    code = 8'h07;
      4'd8:    code = 8'h7f;
      4'd9:    code = 8'h6f;
      default: code = '0;
    endcase
    return code & ~POINT_BIT;
  endfunction

endpackage

[hdl/dsss_if.sv]
`timescale 1ns / 1ps

interface dsss_in_if;
  import dsss_pkg::*;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface dsss_out_if;
  import dsss_pkg::*;
  logic             valid;
  logic             ready;
  logic [SEL_W-1:0] digit_select;
  logic [SEG_W-1:0] segments;
  logic [POS_W-1:0] position;
  logic             last;

  modport source (output valid, output digit_select, output segments,
                  output position, output last, input ready);
  modport sink   (input valid, input digit_select, input segments,
                  input position, input last, output ready);
endinterface

[hdl/decimal_seven_segment_scanner.sv]
`timescale 1ns / 1ps
// Channel   Direction  Payload
// in_ch     sink       value (27 bits, unsigned)
// out_ch    source     digit_select, segments, position, last
//
// A nonzero value passes through the shift-and-add-3 converter, one input bit per
// cycle, and its digits are then handed to the emitter; the converter takes no new
// transaction until that handoff is done.
// The emitter sends one digit per cycle from its digit shift register while the output
// keeps up, overlapping the next conversion; a zero value is taken and produces nothing.
// Reset (rst_n low, synchronous) empties both stages and the output register.
// A stalled output holds its transaction and the converter waits with its digits.

module decimal_seven_segment_scanner #(
  parameter int DIGITS = dsss_pkg::DIGITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst_n,
  dsss_in_if.sink    in_ch,
  dsss_out_if.source out_ch
);
  import dsss_pkg::*;

  // Packed decimal digits travel from the converter to the emitter with a simple
  // valid and ready pair; the converter holds them until the emitter is free.
  logic                    bcd_valid;
  logic                    bcd_ready;
  logic [BCD_W*DIGITS-1:0] bcd_digits;

  // The converter clamps the value to the display limit and turns it into decimal
  // digits one bit per cycle.
  dsss_dabble #(.DIGITS(DIGITS)) u_dabble (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_value   (in_ch.value),
    .bcd_valid  (bcd_valid),
    .bcd_ready  (bcd_ready),
    .bcd_digits (bcd_digits)
  );

  // The emitter shifts the digits out least significant first and stops after the
  // most significant nonzero digit, which blanks the leading zeros.
  dsss_emit #(.DIGITS(DIGITS)) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .bcd_valid  (bcd_valid),
    .bcd_ready  (bcd_ready),
    .bcd_digits (bcd_digits),
    .out_ch     (out_ch)
  );

endmodule

[hdl/dsss_dabble.sv]
`timescale 1ns / 1ps

module dsss_dabble #(
  parameter int DIGITS = dsss_pkg::DIGITS_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [dsss_pkg::VALUE_W-1:0]           in_value,
  output logic                                   bcd_valid,
  input  logic                                   bcd_ready,
  output logic [dsss_pkg::BCD_W*DIGITS-1:0]      bcd_digits
);
  import dsss_pkg::*;

  localparam int BW  = BCD_W * DIGITS;
  localparam int CW  = $clog2(VALUE_W);
  localparam logic [VALUE_W-1:0] LIMIT = display_limit(DIGITS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [VALUE_W-1:0] val_r, val_nxt;
  logic [BW-1:0]      bcd_r, bcd_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [BW-1:0]      adj;
  logic [VALUE_W-1:0] clamped;

  assign clamped    = (in_value > LIMIT) ? LIMIT : in_value;
  assign in_ready   = (state_r == ST_IDLE);
  assign bcd_valid  = (state_r == ST_HOLD);
  assign bcd_digits = bcd_r;

  // Add three to every digit of five or more before the next shift.
  always_comb begin
    for (int d = 0; d < DIGITS; d++) begin
      adj[d*BCD_W +: BCD_W] = (bcd_r[d*BCD_W +: BCD_W] >= 4'd5) ?
                              bcd_r[d*BCD_W +: BCD_W] + 4'd3 :
                              bcd_r[d*BCD_W +: BCD_W];
    end
  end

  always_comb begin
    state_nxt = state_r;
    val_nxt   = val_r;
    bcd_nxt   = bcd_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && (clamped != '0)) begin
          state_nxt = ST_CONV;
          val_nxt   = clamped;
          bcd_nxt   = '0;
          cnt_nxt   = '0;
        end
      end
      ST_CONV: begin
        bcd_nxt = {adj[BW-2:0], val_r[VALUE_W-1]};
        val_nxt = {val_r[VALUE_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(VALUE_W - 1)) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (bcd_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    val_r <= val_nxt;
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
  end

endmodule

[hdl/dsss_emit.sv]
`timescale 1ns / 1ps

module dsss_emit #(
  parameter int DIGITS = dsss_pkg::DIGITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               bcd_valid,
  output logic                               bcd_ready,
  input  logic [dsss_pkg::BCD_W*DIGITS-1:0]  bcd_digits,
  dsss_out_if.source                         out_ch
);
  import dsss_pkg::*;

  localparam int BW = BCD_W * DIGITS;

  logic             busy_r, busy_nxt;
  logic [BW-1:0]    bcd_r, bcd_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             ov_r, ov_nxt;
  logic [SEL_W-1:0] sel_r, sel_nxt;
  logic [SEG_W-1:0] seg_r, seg_nxt;
  logic [POS_W-1:0] opos_r, opos_nxt;
  logic             last_r, last_nxt;
  logic [BW-1:0]    upper;
  logic             step;

  assign upper     = bcd_r >> BCD_W;
  assign step      = busy_r && (!ov_r || out_ch.ready);
  assign bcd_ready = !busy_r;

  always_comb begin
    busy_nxt = busy_r;
    bcd_nxt  = bcd_r;
    pos_nxt  = pos_r;
    ov_nxt   = ov_r && !out_ch.ready;
    sel_nxt  = sel_r;
    seg_nxt  = seg_r;
    opos_nxt = opos_r;
    last_nxt = last_r;
    if (step) begin
      ov_nxt   = 1'b1;
      sel_nxt  = ~(SEL_W'(1) << pos_r);
      seg_nxt  = seg_code(bcd_r[BCD_W-1:0]);
      opos_nxt = pos_r;
      last_nxt = (upper == '0);
      bcd_nxt  = upper;
      pos_nxt  = pos_r + 1'b1;
      if (upper == '0) begin
        busy_nxt = 1'b0;
      end
    end else if (!busy_r && bcd_valid) begin
      busy_nxt = 1'b1;
      bcd_nxt  = bcd_digits;
      pos_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
    bcd_r  <= bcd_nxt;
    pos_r  <= pos_nxt;
    sel_r  <= sel_nxt;
    seg_r  <= seg_nxt;
    opos_r <= opos_nxt;
    last_r <= last_nxt;
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.digit_select = sel_r;
  assign out_ch.segments     = seg_r;
  assign out_ch.position     = opos_r;
  assign out_ch.last         = last_r;

endmodule

[hdl/dsss_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dsss_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [dsss_pkg::SEL_W-1:0]    out_digit_select,
  input logic [dsss_pkg::SEG_W-1:0]    out_segments,
  input logic [dsss_pkg::POS_W-1:0]    out_position,
  input logic                          out_last
);
  import dsss_pkg::*;

  // Position the next digit must carry: zero at the start of every run.
  logic [POS_W-1:0] exp_pos_r, exp_pos_nxt;
  // Everything a waiting transaction carries, and whether one is waiting.
  logic [SEL_W+SEG_W+POS_W:0] payload;
  logic                       stalled;

  assign payload = {out_digit_select, out_segments, out_position, out_last};
  assign stalled = out_valid && !out_ready;

  assign exp_pos_nxt = (out_valid && out_ready) ?
                       (out_last ? '0 : out_position + 1'b1) : exp_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_pos_r <= '0;
    end else begin
      exp_pos_r <= exp_pos_nxt;
    end
  end

  `ASSERT_NEXT(a_valid_hold, clk, rst_n, stalled, out_valid, "valid dropped")
  `ASSERT_NEXT(a_payload_hold, clk, rst_n, stalled, $stable(payload), "payload changed")
  `ASSERT_IMPLY(a_position_seq, clk, rst_n, out_valid, out_position == exp_pos_r, "wrong position")
  `ASSERT_NEXT_RAW(a_reset_idle, clk, !rst_n, !out_valid, "output valid after reset")

endmodule

bind decimal_seven_segment_scanner dsss_checker u_dsss_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_digit_select (out_ch.digit_select),
  .out_segments     (out_ch.segments),
  .out_position     (out_ch.position),
  .out_last         (out_ch.last)
);

[bench/decimal_seven_segment_scanner_tb.sv]
`timescale 1ns / 1ps

// Self-checking bench for the decimal seven-segment scanner. Every value that the
// block accepts is split into decimal digits here, and the display writes that it
// should cause are queued. Each write that leaves the block is then compared, field
// by field, with the oldest queued write. Both channels idle at random, and the
// receiver once holds off long enough for the block to fill up and stall its input.

module decimal_seven_segment_scanner_tb;
  import dsss_pkg::*;

  localparam int          SHOWN_DIGITS = DIGITS_DEFAULT;
  // Largest value that eight positions can show. Anything above it is clamped.
  localparam int unsigned MAX_SHOWN    = 99_999_999;
  localparam int          STALL_LIMIT  = 3000;
  localparam int          TAIL_CYCLES  = 64;
  localparam int          LONG_HOLD    = 300;

  // Common-cathode glyphs for the digits 0 to 9, segments a..g in bits 0..6.
  localparam logic [SEG_W-1:0] GLYPH [10] = '{
    8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
  };

  typedef struct packed {
    logic [SEL_W-1:0] digit_select;
    logic [SEG_W-1:0] segments;
    logic [POS_W-1:0] position;
    logic             last;
  } display_write_t;

  logic clk;
  logic rst_n;

  dsss_in_if  in_ch ();
  dsss_out_if out_ch ();

  decimal_seven_segment_scanner #(
    .DIGITS(SHOWN_DIGITS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Display writes still owed by the block, oldest first.
  display_write_t pending_writes[$];

  int values_taken;
  int writes_checked;
  int fail_count;

  // Idling switches for each side, and a request for one long hold-off on the
  // output that the receiver counts out in its own process.
  bit sender_idles;
  bit sink_idles;
  int hold_request;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Splits one accepted value into the writes it should produce. The value is
  // first clamped to the display limit, and then digits are peeled off from the
  // least significant end until nothing is left, so that leading zeros are blanked
  // but zeros inside the number still appear. A zero value queues nothing.
  function automatic void queue_digit_writes(input logic [VALUE_W-1:0] raw);
    int unsigned    rest;
    int unsigned    digit;
    display_write_t w;
    rest = (raw > MAX_SHOWN) ? MAX_SHOWN : int'(raw);
    for (int pos = 0; pos < SHOWN_DIGITS && rest != 0; pos++) begin
      digit          = rest % 10;
      rest           = rest / 10;
      w.digit_select = ~(SEL_W'(1) << pos);
      w.segments     = GLYPH[digit] & ~POINT_BIT;
      w.position     = POS_W'(pos);
      w.last         = (rest == 0);
      pending_writes.push_back(w);
    end
  endfunction

  function automatic void compare_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 'h%02h, actual 'h%02h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Scoreboard. Outputs are checked before the input of the same edge is
  // predicted; no write can come from a transaction taken in the same cycle, so
  // the order only matters for readability. Everything is sampled at the clock
  // edge, before the block's own updates of that edge take effect.
  always @(posedge clk) begin
    display_write_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_writes.size() == 0) begin
        $display("%0t: unexpected display write, sel 'h%02h seg 'h%02h pos %0d last %0b",
                 $time, out_ch.digit_select, out_ch.segments, out_ch.position, out_ch.last);
        fail_count++;
      end else begin
        want = pending_writes.pop_front();
        compare_field("digit_select", want.digit_select, out_ch.digit_select);
        compare_field("segments", want.segments, out_ch.segments);
        compare_field("position", 8'(want.position), 8'(out_ch.position));
        compare_field("last", 8'(want.last), 8'(out_ch.last));
        writes_checked++;
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      queue_digit_writes(in_ch.value);
      values_taken++;
    end
  end

  // Receiver. Each pass of the loop makes exactly one assignment to ready, so it
  // never lowers and raises it within one time step. A pending hold request takes
  // priority over the ordinary random stalls.
  initial begin : sink_driver
    int span;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_request > 0) begin
        span         = hold_request;
        hold_request = 0;
        out_ch.ready <= 1'b0;
        repeat (span) @(posedge clk);
      end else if (sink_idles && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Ends the run if no transaction moves on either channel for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("decimal_seven_segment_scanner_tb: FAIL");
    $finish;
  end

  // Offers one value and returns at the edge at which it is taken. Valid is left
  // high, so back-to-back values need no second assignment in the same step; a
  // random gap drops it and puts junk on the bus while it is low.
  task automatic send_value(input logic [VALUE_W-1:0] v);
    int gap;
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_ch.valid <= 1'b0;
      in_ch.value <= VALUE_W'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Zero, single digits, zeros inside the number, every digit glyph, the display
  // limit and values above it up to the widest input word.
  task automatic test_directed_values();
    logic [VALUE_W-1:0] picks[$];
    picks = '{0, 1, 5, 9, 10, 100, 90, 12345678, 87654321, 50607080, 1000001,
              10000000, 9999999, 99999998, 99999999, 100000000, 100000001,
              27'h4000000, 27'h7ffffff, 27'h5555555, 27'h2aaaaaa, 0, 7, 3333};
    foreach (picks[k]) send_value(picks[k]);
  endtask

  // Mostly values of a random number of digits, so that every run length is
  // reached often, plus zeros, clamped values and values over the whole word.
  task automatic test_random_values(input int count);
    int unsigned        kind;
    int unsigned        lo;
    logic [VALUE_W-1:0] v;
    for (int n = 0; n < count; n++) begin
      if (n % 15 == 0) sink_idles = ($urandom_range(0, 2) != 0);
      kind = $urandom_range(0, 19);
      if (kind < 2) begin
        v = '0;
      end else if (kind < 5) begin
        v = VALUE_W'($urandom_range(134217727, MAX_SHOWN + 1));
      end else if (kind < 8) begin
        v = VALUE_W'($urandom);
      end else begin
        lo = 1;
        repeat ($urandom_range(0, SHOWN_DIGITS - 1)) lo = lo * 10;
        v = VALUE_W'($urandom_range(lo * 10 - 1, lo));
      end
      send_value(v);
    end
    sink_idles = 1'b1;
  endtask

  // The receiver stops for a long stretch while full eight-digit values keep
  // coming, so the emitter and the converter back up and the input stalls.
  task automatic test_output_stall();
    hold_request = LONG_HOLD;
    repeat (12) send_value(VALUE_W'($urandom_range(MAX_SHOWN, 10000000)));
  endtask

  // Closing stretch with neither side idling.
  task automatic test_full_rate();
    sender_idles = 1'b0;
    sink_idles   = 1'b0;
    repeat (12) send_value(VALUE_W'($urandom_range(MAX_SHOWN, 1)));
    in_ch.valid <= 1'b0;
  endtask

  initial begin
    values_taken   = 0;
    writes_checked = 0;
    fail_count     = 0;
    sender_idles   = 1'b1;
    sink_idles     = 1'b1;
    hold_request   = 0;
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_values();
    test_random_values(60);
    test_output_stall();
    test_full_rate();

    // Let the scoreboard queue the last value first, then drain whatever is still
    // owed and watch a while longer for stray writes.
    @(posedge clk);
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Took %0d values (zeros, clamped and every digit count) and checked %0d writes,",
             values_taken, writes_checked);
    $display("with random stalls on both sides and one long output hold-off.");
    if (fail_count == 0) begin
      $display("decimal_seven_segment_scanner_tb: PASS");
    end else begin
      $display("decimal_seven_segment_scanner_tb: FAIL");
    end
    $finish;
  end

endmodule
